### rtl/mlfq_pkg.sv
// Shared constants and controller/datapath interface types for the tick scheduler.
package mlfq_pkg;
  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned TimeBitsDefault = 16;
  localparam logic [3:0]  QuantumReset    = 4'd4;

  localparam logic FuncAdmit = 1'b0;
  localparam logic FuncTick  = 1'b1;

  typedef struct packed {
    logic admit;     // write the input beat into its slot
    logic clr_scan;  // start a new priority scan
    logic scan_step; // examine the slot under the scan index
    logic decide;    // apply the scheduling decision and form the result
    logic out_load;  // place the result into the output register
  } mlfq_cmd_t;

  typedef struct packed {
    logic scan_last; // scan index is on the last slot
  } mlfq_sts_t;
endpackage

### rtl/mlfq_datapath.sv
// Task tables, round-robin FIFO, serial priority scan and the per-tick decision.
module mlfq_datapath import mlfq_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlfq_cmd_t            cmd_i,
  output mlfq_sts_t            sts_o,
  input  logic [3:0]           quantum_i,
  input  logic [3:0]           slot_i,
  input  logic [TIME_BITS-1:0] arrival_time_i,
  input  logic [TIME_BITS-1:0] burst_time_i,
  input  logic [7:0]           task_priority_i,
  input  logic                 is_tick_i,
  output logic                 ran_valid_o,
  output logic [3:0]           ran_slot_o,
  output logic                 ran_level_o,
  output logic                 first_run_o,
  output logic [TIME_BITS-1:0] resp_delay_o,
  output logic                 finished_o,
  output logic [TIME_BITS-1:0] done_tick_o,
  output logic [TIME_BITS-1:0] wait_ticks_o,
  output logic [TIME_BITS-1:0] now_o
);
  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam logic [SW-1:0] LastSlot = SW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] FullCount = CW'(NUM_SLOTS);

  logic [TIME_BITS-1:0] remaining_q [NUM_SLOTS];
  logic [TIME_BITS-1:0] burst_q     [NUM_SLOTS];
  logic [TIME_BITS-1:0] arrival_q   [NUM_SLOTS];
  logic [7:0]           prio_q      [NUM_SLOTS];
  logic [SW-1:0]        fifo_q      [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] demoted_q, started_q;
  logic [3:0]           slice_q     [NUM_SLOTS];
  logic [SW-1:0]        head_q;
  logic [CW-1:0]        count_q;
  logic                 last_valid_q;
  logic [SW-1:0]        last_top_q;
  logic [TIME_BITS-1:0] tick_q;
  logic [SW-1:0]        idx_q, best_slot_q;
  logic [7:0]           best_prio_q;
  logic                 found_q;

  // Registered result.
  logic                 rv_q, rl_q, fr_q, fn_q;
  logic [SW-1:0]        rs_q;
  logic [TIME_BITS-1:0] resp_q, ft_q, wt_q, now_q;

  logic [3:0] q_eff;
  assign q_eff = (quantum_i == 4'd0) ? 4'd1 : quantum_i;

  // Slot numbers are narrower than 4 bits only for small NUM_SLOTS.
  logic [SW-1:0] admit_slot;
  logic          admit_ok;
  always_comb begin
    admit_slot = SW'(slot_i);
    admit_ok   = ({28'd0, slot_i} < NUM_SLOTS);
  end

  logic elig;
  assign elig = (arrival_q[idx_q] <= tick_q) && (remaining_q[idx_q] != '0) &&
                !demoted_q[idx_q] && (!found_q || prio_q[idx_q] < best_prio_q);
  assign sts_o.scan_last = (idx_q == LastSlot);

  // Sequenced decision: compute the whole tick update in one combinational pass.
  logic [TIME_BITS-1:0] rem_n [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] dem_n, st_n;
  logic [3:0]           sl_n [NUM_SLOTS];
  logic [SW-1:0]        fifo_n [NUM_SLOTS];
  logic [SW-1:0]        head_n;
  logic [CW-1:0]        count_n;
  logic                 lv_n;
  logic [SW-1:0]        lt_n;
  logic                 ran, lvl, first, fin;
  logic [SW-1:0]        s;
  logic [SW-1:0]        h;
  logic [TIME_BITS-1:0] svc, resp, ftime, wtime;

  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a, input logic [CW-1:0] b);
    logic [SW:0] t;
    t = {1'b0, a} + (SW+1)'(b);
    if (t >= (SW+1)'(NUM_SLOTS)) t = t - (SW+1)'(NUM_SLOTS);
    return t[SW-1:0];
  endfunction

  always_comb begin
    rem_n = remaining_q; dem_n = demoted_q; st_n = started_q; sl_n = slice_q;
    fifo_n = fifo_q; head_n = head_q; count_n = count_q;
    lv_n = last_valid_q; lt_n = last_top_q;
    ran = 1'b0; lvl = 1'b0; first = 1'b0; fin = 1'b0; s = best_slot_q;
    h = fifo_q[head_q];
    resp = '0; ftime = '0; wtime = '0; svc = '0;
    if (!found_q && count_q != '0) begin
      lv_n = 1'b0;
      if (remaining_q[h] == '0) begin
        head_n = wrap_add(head_q, CW'(1)); count_n = count_q - CW'(1);
      end else if (slice_q[h] >= q_eff) begin
        sl_n[h] = '0;
        // Rotation: pop then push at the tail, which with a full queue is the freed entry.
        fifo_n[wrap_add(head_q, count_q)] = h;
        head_n = wrap_add(head_q, CW'(1));
      end else begin
        ran = 1'b1; s = h; lvl = 1'b1;
        sl_n[h] = slice_q[h] + 4'd1;
        rem_n[h] = remaining_q[h] - TIME_BITS'(1);
        if (rem_n[h] == '0) begin
          fin = 1'b1;
          head_n = wrap_add(head_q, CW'(1)); count_n = count_q - CW'(1);
        end else if (sl_n[h] >= q_eff) begin
          sl_n[h] = '0;
          fifo_n[wrap_add(head_q, count_q)] = h;
          head_n = wrap_add(head_q, CW'(1));
        end
      end
    end else begin
      if (found_q && count_q != '0 && !last_valid_q) begin
        if (slice_q[h] != '0 && slice_q[h] <= q_eff) begin
          fifo_n[wrap_add(head_q, count_q)] = h;
          head_n = wrap_add(head_q, CW'(1));
        end
      end
      if (last_valid_q && (!found_q || best_slot_q != last_top_q) &&
          !demoted_q[last_top_q]) begin
        if (count_n != FullCount) begin
          fifo_n[wrap_add(head_n, count_n)] = last_top_q;
          count_n = count_n + CW'(1);
        end
        dem_n[last_top_q] = 1'b1;
      end
      if (found_q) begin
        ran = 1'b1;
        rem_n[s] = remaining_q[s] - TIME_BITS'(1);
        svc = burst_q[s] - rem_n[s];
        if (rem_n[s] == '0) begin
          fin = 1'b1; dem_n[s] = 1'b1;
        end else if (svc >= TIME_BITS'(q_eff)) begin
          dem_n[s] = 1'b1;
          if (count_n != FullCount) begin
            fifo_n[wrap_add(head_n, count_n)] = s;
            count_n = count_n + CW'(1);
          end
        end
      end
      lv_n = found_q; lt_n = best_slot_q;
    end
    if (ran) begin
      if (!started_q[s]) begin
        st_n[s] = 1'b1; first = 1'b1;
        resp = tick_q - arrival_q[s];
      end
      if (fin) begin
        ftime = tick_q + TIME_BITS'(1);
        wtime = ftime - burst_q[s] - arrival_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        remaining_q[i] <= '0;
        slice_q[i]     <= '0;
      end
      demoted_q <= '0; started_q <= '0;
      head_q <= '0; count_q <= '0;
      last_valid_q <= 1'b0; last_top_q <= '0; tick_q <= '0;
      idx_q <= '0; found_q <= 1'b0; best_slot_q <= '0;
      rv_q <= 1'b0;
    end else begin
      if (cmd_i.admit && admit_ok) begin
        remaining_q[admit_slot] <= burst_time_i;
        demoted_q[admit_slot]   <= 1'b0;
        started_q[admit_slot]   <= 1'b0;
        slice_q[admit_slot]     <= '0;
      end
      if (cmd_i.clr_scan) begin
        idx_q <= '0; found_q <= 1'b0; best_slot_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (elig) begin
          found_q <= 1'b1; best_slot_q <= idx_q;
        end
        if (idx_q != LastSlot) idx_q <= idx_q + SW'(1);
      end
      if (cmd_i.decide) begin
        remaining_q <= rem_n; demoted_q <= dem_n; started_q <= st_n;
        slice_q <= sl_n; head_q <= head_n; count_q <= count_n;
        last_valid_q <= lv_n; last_top_q <= lt_n;
        tick_q <= tick_q + TIME_BITS'(1);
      end
      if (cmd_i.out_load) rv_q <= is_tick_i ? ran : 1'b0;
    end
  end

  // Payload tables need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.admit && admit_ok) begin
      arrival_q[admit_slot] <= arrival_time_i;
      burst_q[admit_slot]   <= burst_time_i;
      prio_q[admit_slot]    <= task_priority_i;
    end
    if (cmd_i.scan_step && elig) best_prio_q <= prio_q[idx_q];
    if (cmd_i.decide) fifo_q <= fifo_n;
    if (cmd_i.out_load) begin
      now_q <= tick_q;
      if (is_tick_i && ran) begin
        rs_q <= s; rl_q <= lvl; fr_q <= first; fn_q <= fin;
        resp_q <= resp; ft_q <= ftime; wt_q <= wtime;
      end else begin
        rs_q <= '0; rl_q <= 1'b0; fr_q <= 1'b0; fn_q <= 1'b0;
        resp_q <= '0; ft_q <= '0; wt_q <= '0;
      end
    end
  end

  assign ran_valid_o  = rv_q;
  assign ran_slot_o   = 4'(rs_q);
  assign ran_level_o  = rl_q;
  assign first_run_o  = fr_q;
  assign resp_delay_o = resp_q;
  assign finished_o   = fn_q;
  assign done_tick_o  = ft_q;
  assign wait_ticks_o = wt_q;
  assign now_o        = now_q;
endmodule

### rtl/mlfq_ctrl.sv
// Sequencer: accepts beats, runs the serial scan and hands results out.
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      func_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mlfq_sts_t sts_i,
  output mlfq_cmd_t cmd_o,
  output logic      is_tick_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDec  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ov_q, ov_d, tick_q, tick_d;
  logic       acc;

  // A new beat may enter in the idle state once the output register is free or being drained.
  assign in_ready_o = (state_q == StIdle) && (!ov_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  // An admit result is loaded from the idle state, where the stored kind is stale.
  assign is_tick_o   = tick_q && (state_q != StIdle);

  always_comb begin
    state_d = state_q; ov_d = ov_q; tick_d = tick_q;
    cmd_o = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          tick_d = (func_i == FuncTick);
          if (func_i == FuncAdmit) begin
            cmd_o.admit = 1'b1; cmd_o.out_load = 1'b1; ov_d = 1'b1;
          end else begin
            cmd_o.clr_scan = 1'b1; state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = StDec;
      end
      StDec: begin
        cmd_o.decide = 1'b1; cmd_o.out_load = 1'b1;
        ov_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ov_q <= 1'b0; tick_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; tick_q <= tick_d;
    end
  end
endmodule

### rtl/mlfq_tick_scheduler.sv
// Top level of the two-level feedback queue tick scheduler.
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | func, slot, times, priority
//   out     | output    | out_valid_o/out_ready_i | ran_*, times, now
//   cfg     | input     | quantum_we_i            | quantum_i
// An admit beat is taken and loaded from the idle state; a tick beat passes through
// the scan and decide states, the serial priority scan reading one slot per cycle.
// Reset clears all control state and the remaining/status tables at once.
// A waiting result holds in the output register; the next beat is taken
// in the cycle that result is drained.
module mlfq_tick_scheduler import mlfq_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 quantum_we_i,
  input  logic [3:0]           quantum_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [3:0]           slot_i,
  input  logic [TIME_BITS-1:0] arrival_time_i,
  input  logic [TIME_BITS-1:0] burst_time_i,
  input  logic [7:0]           task_priority_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 ran_valid_o,
  output logic [3:0]           ran_slot_o,
  output logic                 ran_level_o,
  output logic                 first_run_o,
  output logic [TIME_BITS-1:0] resp_delay_o,
  output logic                 finished_o,
  output logic [TIME_BITS-1:0] done_tick_o,
  output logic [TIME_BITS-1:0] wait_ticks_o,
  output logic [TIME_BITS-1:0] now_o
);
  logic [3:0] quantum_q;
  mlfq_cmd_t  cmd;
  mlfq_sts_t  sts;
  logic       is_tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QuantumReset;
    else if (quantum_we_i) quantum_q <= quantum_i;
  end

  mlfq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd), .is_tick_o(is_tick)
  );

  mlfq_datapath #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .quantum_i(quantum_q),
    .slot_i, .arrival_time_i, .burst_time_i, .task_priority_i,
    .is_tick_i(is_tick), .ran_valid_o, .ran_slot_o, .ran_level_o, .first_run_o,
    .resp_delay_o, .finished_o, .done_tick_o, .wait_ticks_o, .now_o
  );
endmodule

### rtl/mlfq_checker.sv
// Port-level checker for the tick scheduler, bound to the top level.
module mlfq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ran_valid_o,
  input logic       finished_o,
  input logic       first_run_o,
  input logic [3:0] ran_slot_o
);
  // The output register holds its result until it is drained.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ran_slot_o))
    else $error("result changed while stalled");

  // A completion or a first run is only reported when a task ran.
  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (finished_o || first_run_o) |-> ran_valid_o)
    else $error("completion without a running task");

  // After an accepted beat, the next cycle shows a valid result or holds off new input.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("accepted beat produced no result");

  // A stalled result blocks new input.
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
endmodule

bind mlfq_tick_scheduler mlfq_checker u_mlfq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .ran_valid_o, .finished_o, .first_run_o, .ran_slot_o
);
